// ===== rtl/core/vppp_pkg.sv =====
// Package for the vibration pulse pattern player.
// Holds the item kinds, register indexes, table geometry and timing constants.
// No dependencies.
package vppp_pkg;

    localparam int PATTERN_DEPTH = 16;
    localparam int TBL_IDX_W     = $clog2(PATTERN_DEPTH);
    localparam int PTR_W         = 5;
    localparam int CFG_W         = 16;
    localparam int MS_W          = 16;
    localparam int DELTA_W       = 20;
    localparam int ENTRY_IDX_W   = 4;
    localparam int HZ_W          = 16;
    localparam int ELAPSED_W     = 32;
    localparam int US_PER_MS     = 1000;
    localparam int LIMIT_W       = $clog2((2 ** MS_W - 1) * US_PER_MS + 1);
    localparam logic [HZ_W-1:0] DEFAULT_HZ = HZ_W'(80);

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_PLAY  = 2'd2,
        KIND_STOP  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_LOOP_ENABLE    = 2'd1,
        CFG_TONE_FREQUENCY = 2'd2
    } cfg_index_t;

endpackage

// ===== rtl/core/vibration_pulse_pattern_player.sv =====
// Top level of the vibration pulse pattern player.
// Holds the pulse table, the playback state and the result register.
// Depends on vppp_pkg.
// Usage:
// Items enter on the s_axis channel: s_axis_tuser carries the kind (tick,
// table write, play, stop) and s_axis_tdata the tick delta and the entry
// fields. Every accepted item yields exactly one result item on m_axis,
// carrying the tone enable, the effective tone frequency, the playing flag
// and the current entry index.
// m_axis_tvalid rises in the cycle after acceptance. Throughput is one
// item per cycle unless stalled: the playback state is updated in a single
// pass from the state registers, with the on and off limits premultiplied
// to microseconds in the table so a tick needs one add and one compare.
// The cfg port writes pattern_length, loop_enable and tone_frequency;
// the user must write only while no item is in flight (not enforced).
// When the receiver stalls, the result stays in the output register and
// s_axis_tready drops until it is taken, so no item is lost.
// Reset stops playback, clears the state and configuration registers and
// empties the output register. The pulse table holds no reset value and
// must be written before entries are played.
module vibration_pulse_pattern_player
    import vppp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // delta_us[19:0], entry_index[23:20], on_ms[39:24], off_ms[55:40]
    input  logic [55:0]          s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tone_on[0], tone_hz[16:1], is_playing[17], current_entry[22:18]
    output logic [23:0]          m_axis_tdata,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [PTR_W-1:0]     pattern_length_reg;
    logic                 loop_enable_reg;
    logic [HZ_W-1:0]      tone_frequency_reg;

    logic                 active_reg, active_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                 silence_reg, silence_next;
    logic                 tone_reg, tone_next;

    logic [LIMIT_W-1:0]   on_lim_mem  [PATTERN_DEPTH];
    logic [LIMIT_W-1:0]   off_lim_mem [PATTERN_DEPTH];
    logic                 on_zero_mem [PATTERN_DEPTH];

    logic                 out_valid_reg;
    logic [23:0]          out_data_reg;

    logic                 in_fire;
    kind_t                kind;
    logic [DELTA_W-1:0]   delta_us;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [MS_W-1:0]      on_ms;
    logic [MS_W-1:0]      off_ms;
    logic [PTR_W-1:0]     eff_count;
    logic [HZ_W-1:0]      eff_hz;
    logic [LIMIT_W-1:0]   cur_on_lim;
    logic [LIMIT_W-1:0]   cur_off_lim;
    logic [PTR_W-1:0]     start_ptr;
    logic                 start_zero;

    assign kind        = kind_t'(s_axis_tuser);
    assign delta_us    = s_axis_tdata[19:0];
    assign entry_index = s_axis_tdata[23:20];
    assign on_ms       = s_axis_tdata[39:24];
    assign off_ms      = s_axis_tdata[55:40];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign eff_count = (pattern_length_reg < PTR_W'(PATTERN_DEPTH)) ?
                       pattern_length_reg : PTR_W'(PATTERN_DEPTH);
    assign eff_hz    = (tone_frequency_reg == '0) ? DEFAULT_HZ : tone_frequency_reg;

    assign cur_on_lim  = on_lim_mem[ptr_reg[TBL_IDX_W-1:0]];
    assign cur_off_lim = off_lim_mem[ptr_reg[TBL_IDX_W-1:0]];
    assign start_zero  = on_zero_mem[start_ptr[TBL_IDX_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            loop_enable_reg    <= 1'b0;
            tone_frequency_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[PTR_W-1:0];
                CFG_LOOP_ENABLE:    loop_enable_reg    <= cfg_wdata[0];
                CFG_TONE_FREQUENCY: tone_frequency_reg <= cfg_wdata[HZ_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && kind == KIND_WRITE &&
            ({1'b0, entry_index} < (ENTRY_IDX_W + 1)'(PATTERN_DEPTH)))
        begin
            on_lim_mem[entry_index[TBL_IDX_W-1:0]] <=
                LIMIT_W'(LIMIT_W'(on_ms) * LIMIT_W'(US_PER_MS));
            off_lim_mem[entry_index[TBL_IDX_W-1:0]] <=
                LIMIT_W'(LIMIT_W'(off_ms) * LIMIT_W'(US_PER_MS));
            on_zero_mem[entry_index[TBL_IDX_W-1:0]] <= (on_ms == '0);
        end
    end

    always_comb
    begin
        logic [ELAPSED_W:0]   sum;
        logic [ELAPSED_W-1:0] sat;
        logic [PTR_W-1:0]     inc_ptr;
        logic                 do_start;

        active_next  = active_reg;
        ptr_next     = ptr_reg;
        elapsed_next = elapsed_reg;
        silence_next = silence_reg;
        tone_next    = tone_reg;
        do_start     = 1'b0;
        start_ptr    = '0;

        sum     = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(delta_us);
        sat     = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
        inc_ptr = PTR_W'(ptr_reg + 1'b1);

        case (kind)
            KIND_TICK:
            begin
                if (active_reg)
                begin
                    if (ptr_reg >= eff_count)
                    begin
                        active_next  = 1'b0;
                        tone_next    = 1'b0;
                        ptr_next     = '0;
                        elapsed_next = '0;
                        silence_next = 1'b0;
                    end
                    else if (!silence_reg)
                    begin
                        if (sat < ELAPSED_W'(cur_on_lim))
                        begin
                            elapsed_next = sat;
                        end
                        else
                        begin
                            tone_next    = 1'b0;
                            elapsed_next = '0;
                            silence_next = 1'b1;
                        end
                    end
                    else if (sat < ELAPSED_W'(cur_off_lim))
                    begin
                        elapsed_next = sat;
                    end
                    else if (inc_ptr < eff_count)
                    begin
                        start_ptr = inc_ptr;
                        do_start  = 1'b1;
                    end
                    else if (loop_enable_reg)
                    begin
                        start_ptr = '0;
                        do_start  = 1'b1;
                    end
                    else
                    begin
                        active_next  = 1'b0;
                        tone_next    = 1'b0;
                        ptr_next     = '0;
                        elapsed_next = '0;
                        silence_next = 1'b0;
                    end
                end
            end
            KIND_WRITE:
            begin
            end
            KIND_PLAY:
            begin
                if (eff_count != '0)
                begin
                    active_next = 1'b1;
                    start_ptr   = '0;
                    do_start    = 1'b1;
                end
            end
            KIND_STOP:
            begin
                active_next  = 1'b0;
                tone_next    = 1'b0;
                ptr_next     = '0;
                elapsed_next = '0;
                silence_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        if (do_start)
        begin
            ptr_next     = start_ptr;
            elapsed_next = '0;
            tone_next    = !start_zero;
            silence_next = start_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            ptr_reg       <= '0;
            elapsed_reg   <= '0;
            silence_reg   <= 1'b0;
            tone_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                active_reg    <= active_next;
                ptr_reg       <= ptr_next;
                elapsed_reg   <= elapsed_next;
                silence_reg   <= silence_next;
                tone_reg      <= tone_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= {1'b0, ptr_next, active_next, eff_hz, tone_next};
        end
    end

`ifndef SYNTHESIS
    a_idle_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (ptr_reg == '0) && !tone_reg && !silence_reg)
        else $error("Stopped player holds a nonzero pointer or a driven tone.");

    a_tone_not_silent: assert property (@(posedge clk) disable iff (!rst_n)
        tone_reg |-> !silence_reg)
        else $error("Tone driven during a silence phase.");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> m_axis_tvalid)
        else $error("Accepted item produced no result.");

    a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && kind == KIND_STOP |=> !active_reg && !m_axis_tdata[17])
        else $error("Stop item left the player running.");
`endif

endmodule
